// ===== rtl/core/kcl_pkg.sv =====
// kcl_pkg: shared types and constants of the keypad code lock
// no dependencies; imported by kcl_csr, kcl_core and keypad_code_lock_unit

package kcl_pkg;

   // fixed field widths
   localparam int KEY_W       = 2;
   localparam int CODE_W      = 8;
   localparam int CODE_DIGITS = 4;
   localparam int NUM_CODE_REGS = 3;
   localparam int ERR_W       = 4;
   localparam int TICK_W      = 8;
   localparam int MATCH_W     = 2;
   localparam int DIGITS_W    = 3;
   localparam int OUTCOME_W   = 3;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;

   // saturation limits
   localparam logic [ERR_W-1:0]  ERR_MAX  = '1;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   // register reset values
   localparam logic [CODE_W-1:0] CODE_A_RST        = 8'd0;
   localparam logic [CODE_W-1:0] CODE_B_RST        = 8'd85;
   localparam logic [CODE_W-1:0] CODE_C_RST        = 8'd170;
   localparam logic [ERR_W-1:0]  MAX_ERRORS_RST    = 4'd10;
   localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = 8'd60;
   localparam logic [TICK_W-1:0] IDLE_TICKS_RST    = 8'd100;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CODE_A        = 3'd0,
      CSR_CODE_B        = 3'd1,
      CSR_CODE_C        = 3'd2,
      CSR_MAX_ERRORS    = 3'd3,
      CSR_LOCKOUT_TICKS = 3'd4,
      CSR_IDLE_TICKS    = 3'd5
   } csr_addr_type;

   // event kinds
   typedef enum logic [KEY_W-1:0] {
      ACT_DIGIT = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_TICK  = 2'd2
   } action_type;

   // result codes
   typedef enum logic [OUTCOME_W-1:0] {
      OUT_NONE    = 3'd0,
      OUT_IGNORED = 3'd1,
      OUT_TAKEN   = 3'd2,
      OUT_OPEN    = 3'd3,
      OUT_REJECT  = 3'd4
   } outcome_type;

   // configuration seen by the lock logic
   typedef struct packed {
      logic [NUM_CODE_REGS-1:0][CODE_W-1:0] code;
      logic [ERR_W-1:0]                     max_errors;
      logic [TICK_W-1:0]                    lockout_ticks;
      logic [TICK_W-1:0]                    idle_ticks;
   } cfg_type;

   // one accepted event
   typedef struct packed {
      logic [KEY_W-1:0] action;
      logic [KEY_W-1:0] key;
   } item_type;

   // one result
   typedef struct packed {
      logic [DIGITS_W-1:0]  digits_entered;
      logic                 locked_out;
      logic [MATCH_W-1:0]   matched_code;
      logic                 clear_tone;
      logic [OUTCOME_W-1:0] outcome;
   } rsp_type;

endpackage

// ===== rtl/core/kcl_csr.sv =====
// kcl_csr: configuration registers of the keypad code lock
// depends on kcl_pkg

module kcl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [kcl_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [kcl_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output kcl_pkg::cfg_type                    cfg
);
   import kcl_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // write decode, registers are masked to their width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_CODE_A:        cfg_in.code[0]       = csr_wdata;
            CSR_CODE_B:        cfg_in.code[1]       = csr_wdata;
            CSR_CODE_C:        cfg_in.code[2]       = csr_wdata;
            CSR_MAX_ERRORS:    cfg_in.max_errors    = csr_wdata[ERR_W-1:0];
            CSR_LOCKOUT_TICKS: cfg_in.lockout_ticks = csr_wdata;
            CSR_IDLE_TICKS:    cfg_in.idle_ticks    = csr_wdata;
            default: ;
         endcase
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code[0]       <= CODE_A_RST;
         cfg_ff.code[1]       <= CODE_B_RST;
         cfg_ff.code[2]       <= CODE_C_RST;
         cfg_ff.max_errors    <= MAX_ERRORS_RST;
         cfg_ff.lockout_ticks <= LOCKOUT_TICKS_RST;
         cfg_ff.idle_ticks    <= IDLE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/kcl_core.sv =====
// kcl_core: lock state and the combinational event step
// depends on kcl_pkg; configuration comes from kcl_csr

module kcl_core #(
   parameter int CODE_LEN  = 4,
   parameter int NUM_CODES = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  kcl_pkg::cfg_type  cfg,
   input  logic              step,
   input  kcl_pkg::item_type item,
   output kcl_pkg::rsp_type  rsp
);
   import kcl_pkg::*;

   localparam int CNT_W = $clog2(CODE_LEN + 1);

   logic [CODE_LEN-1:0][KEY_W-1:0]  keys_ff, keys_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [NUM_CODES-1:0]            used_ff, used_in;
   logic [ERR_W-1:0]                err_ff, err_in;
   logic [TICK_W-1:0]               lock_ff, lock_in;
   logic [TICK_W-1:0]               idle_ff, idle_in;
   logic                            timer_ff, timer_in;

   logic [NUM_CODES-1:0][CODE_LEN-1:0][KEY_W-1:0] code_dig;
   logic [NUM_CODES-1:0]            code_hit;
   logic [TICK_W-1:0]               idle_inc;
   logic [CNT_W-1:0]                cnt_sum;
   logic                            hit;
   outcome_type                     outcome;
   logic                            clear_tone;
   logic [MATCH_W-1:0]              matched;

   // expected digits per code; missing codes and digits read as key 0
   for (genvar k = 0; k < NUM_CODES; k++) begin : g_code
      for (genvar i = 0; i < CODE_LEN; i++) begin : g_dig
         if (k < NUM_CODE_REGS && i < CODE_DIGITS) begin : g_real
            assign code_dig[k][i] = cfg.code[k][KEY_W*i +: KEY_W];
         end else begin : g_zero
            assign code_dig[k][i] = '0;
         end
      end
      // codes beyond the register set never match
      if (k < NUM_CODE_REGS) begin : g_cmp
         assign code_hit[k] = !used_ff[k] && (keys_in == code_dig[k]);
      end else begin : g_none
         assign code_hit[k] = 1'b0;
      end
   end

   // event step
   always_comb begin
      keys_in    = keys_ff;
      cnt_in     = cnt_ff;
      used_in    = used_ff;
      err_in     = err_ff;
      lock_in    = lock_ff;
      idle_in    = idle_ff;
      timer_in   = timer_ff;
      outcome    = OUT_NONE;
      clear_tone = 1'b0;
      matched    = '0;
      hit        = 1'b0;
      idle_inc   = (idle_ff != TICK_MAX) ? idle_ff + 1'b1 : idle_ff;
      cnt_sum    = '0;

      unique case (action_type'(item.action)) inside
         ACT_TICK: begin
            if (timer_ff) begin
               if (err_ff >= cfg.max_errors && lock_ff != TICK_MAX)
                  lock_in = lock_ff + 1'b1;
               idle_in = idle_inc;
               // idle timeout drops the entry and the errors
               if (idle_inc > cfg.idle_ticks) begin
                  cnt_in   = '0;
                  idle_in  = '0;
                  err_in   = '0;
                  timer_in = 1'b0;
               end
            end
         end
         ACT_DIGIT, ACT_CLEAR: begin
            timer_in = 1'b1;
            idle_in  = '0;
            if (err_ff >= cfg.max_errors && lock_ff <= cfg.lockout_ticks) begin
               outcome = OUT_IGNORED;
            end else begin
               // lockout over: start from a clean slate
               if (err_ff >= cfg.max_errors) begin
                  err_in  = '0;
                  lock_in = '0;
               end
               if (item.action == ACT_DIGIT) begin
                  for (int i = 0; i < CODE_LEN; i++) begin
                     if (cnt_ff == CNT_W'(i)) keys_in[i] = item.key;
                  end
                  cnt_sum = cnt_ff + 1'b1;
               end else begin
                  keys_in    = '0;
                  lock_in    = '0;
                  clear_tone = 1'b1;
               end
               if (cnt_sum < CNT_W'(CODE_LEN)) begin
                  outcome = OUT_TAKEN;
                  cnt_in  = cnt_sum;
               end else begin
                  // first unused code that matches wins
                  for (int k = 0; k < NUM_CODES; k++) begin
                     if (!hit && code_hit[k]) begin
                        hit        = 1'b1;
                        matched    = MATCH_W'(k);
                        used_in[k] = 1'b1;
                     end
                  end
                  if (hit) begin
                     outcome = OUT_OPEN;
                     err_in  = '0;
                  end else begin
                     outcome = OUT_REJECT;
                     if (err_in != ERR_MAX) err_in = err_in + 1'b1;
                  end
                  cnt_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp.outcome        = outcome;
   assign rsp.clear_tone     = clear_tone;
   assign rsp.matched_code   = matched;
   assign rsp.locked_out     = (err_in >= cfg.max_errors);
   assign rsp.digits_entered = DIGITS_W'(cnt_in);

   // state update on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff  <= '0;
         cnt_ff   <= '0;
         used_ff  <= '0;
         err_ff   <= '0;
         lock_ff  <= '0;
         idle_ff  <= '0;
         timer_ff <= 1'b0;
      end else if (step) begin
         keys_ff  <= keys_in;
         cnt_ff   <= cnt_in;
         used_ff  <= used_in;
         err_ff   <= err_in;
         lock_ff  <= lock_in;
         idle_ff  <= idle_in;
         timer_ff <= timer_in;
      end
   end

`ifndef SYNTHESIS
   // entry buffer never holds a full code between steps
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(CODE_LEN))
      else $error("entry count reached code length");

   // an opened lock leaves no errors behind
   assert property (@(posedge clock) disable iff (reset)
      step && outcome == OUT_OPEN |=> err_ff == '0)
      else $error("error count not cleared after open");

   // an ignored key leaves the entry alone
   assert property (@(posedge clock) disable iff (reset)
      step && outcome == OUT_IGNORED |=> cnt_ff == $past(cnt_ff))
      else $error("ignored key changed the entry");

   // used codes are never freed
   assert property (@(posedge clock) disable iff (reset || $past(reset))
      (used_ff & $past(used_ff)) == $past(used_ff))
      else $error("used code became free");
`endif

endmodule

// ===== rtl/core/keypad_code_lock_unit.sv =====
// keypad_code_lock_unit: a request passes the input register, then the step logic
// into the response register, before its response is valid and can transfer
// throughput one event per cycle while responses are taken; a waiting response holds the input register,
// so the request side takes at most one more event and then waits for rsp_tready
// reset is synchronous and active high; it loads the register defaults and
// clears the entry, errors, counters, used codes and both pipeline stages

module keypad_code_lock_unit #(
   parameter int CODE_LEN  = 4,
   parameter int NUM_CODES = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kcl_pkg::REQ_DATA_W-1:0]    req_tdata,  // [1:0] key, rest zero
   input  logic [kcl_pkg::KEY_W-1:0]         req_tuser,  // [1:0] action
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] outcome, [3] clear_tone, [5:4] matched_code, [6] locked_out,
   // [9:7] digits_entered, rest zero
   output logic [kcl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration writes
   input  logic                              csr_we,
   input  logic [kcl_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [kcl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import kcl_pkg::*;

   cfg_type  cfg;
   item_type in_ff;
   logic     in_vld_ff;
   rsp_type  rsp_step;
   rsp_type  rsp_ff;
   logic     rsp_vld_ff;
   logic     advance;

   kcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input stage moves into the response register when that slot frees up
   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.action <= req_tuser;
         in_ff.key    <= req_tdata[KEY_W-1:0];
      end
   end

   kcl_core #(
      .CODE_LEN  (CODE_LEN),
      .NUM_CODES (NUM_CODES)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (advance),
      .item  (in_ff),
      .rsp   (rsp_step)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_step;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

`ifndef SYNTHESIS
   // a waiting response is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_tready |-> !advance)
      else $error("pending response overwritten");

   // input stage is never dropped without a transfer onward
   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff)
      else $error("input stage lost an event");

   // every step produces a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("step without response");
`endif

endmodule
